### hw/rtl/euler_zyz_to_rotation_matrix_top_assert.svh
// Assertion macros used by the top-level RTL.
`ifndef EULER_ZYZ_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ZYZ_TO_ROTATION_MATRIX_TOP_ASSERT_SVH

// Implication checked every clock, muted in reset.
`define EZ_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, muted in reset.
`define EZ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### hw/rtl/ezr_pkg.sv
package ezr_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 14;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FIELD_W           = 16;

  // CORDIC datapath: 32 fraction bits plus sign and headroom
  localparam int CW = 36;
  localparam logic [CW-1:0] CORDIC_GAIN = CW'(64'd2608131496);

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_lut(input int i);
    logic [31:0] t [32];
    t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
          32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
          32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
          32'd166886, 32'd83443, 32'd41722, 32'd20861,
          32'd10430, 32'd5215, 32'd2608, 32'd1304,
          32'd652, 32'd326, 32'd163, 32'd81,
          32'd41, 32'd20, 32'd10, 32'd5,
          32'd3, 32'd1, 32'd1, 32'd0};
    return t[i & 31];
  endfunction

endpackage

### hw/rtl/euler_zyz_to_rotation_matrix_top.sv
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / stall | phi, theta, psi
// out     | output    | out_valid / out_stall | m_xx .. m_zz
//
// One transaction per cycle while the output is not held by a stall.
// Three CORDIC lanes run side by side, one per angle; a merge block
// builds the matrix. Reset (rst, synchronous) clears only valid bits.
// A stall at the output freezes the whole pipeline; in_stall follows it.
module euler_zyz_to_rotation_matrix_top import ezr_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] phi,
  input  logic signed [FIELD_W-1:0] theta,
  input  logic signed [FIELD_W-1:0] psi,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] m_xx, m_xy, m_xz,
  output logic signed [FIELD_W-1:0] m_yx, m_yy, m_yz,
  output logic signed [FIELD_W-1:0] m_zx, m_zy, m_zz
);

  `include "euler_zyz_to_rotation_matrix_top_assert.svh"

  localparam int LAT = CORDIC_STAGES + 4;

  logic             en;
  logic [LAT-1:0]   vld;
  logic signed [FRAC_BITS+1:0] sf, cf, st, ct, sp, cp;
  logic [FIELD_W-1:0] m [9];

  // whole pipe advances unless a valid result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // three lanes
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
               .CORDIC_STAGES(CORDIC_STAGES)) u_phi (
    .clk(clk), .en(en), .angle(phi), .sin_q(sf), .cos_q(cf));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
               .CORDIC_STAGES(CORDIC_STAGES)) u_theta (
    .clk(clk), .en(en), .angle(theta), .sin_q(st), .cos_q(ct));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
               .CORDIC_STAGES(CORDIC_STAGES)) u_psi (
    .clk(clk), .en(en), .angle(psi), .sin_q(sp), .cos_q(cp));

  ezr_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .en(en), .sf(sf), .cf(cf), .st(st), .ct(ct), .sp(sp), .cp(cp),
    .m(m));

  assign m_xx = m[0]; assign m_xy = m[1]; assign m_xz = m[2];
  assign m_yx = m[3]; assign m_yy = m[4]; assign m_yz = m[5];
  assign m_zx = m[6]; assign m_zy = m[7]; assign m_zz = m[8];

  `EZ_ASSERT_IMP(a_stall_only_on_hold, clk, rst, in_stall, out_valid && out_stall)
  `EZ_ASSERT_NEXT(a_hold_keeps_valid, clk, rst, out_valid && out_stall, out_valid)
  `EZ_ASSERT_NEXT(a_hold_keeps_data, clk, rst, out_valid && out_stall, $stable(m_zz))

endmodule

### hw/rtl/ezr_cordic.sv
// Pipelined rotation-mode CORDIC: one angle per cycle while en is high, sine and cosine out.
module ezr_cordic import ezr_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [FIELD_W-1:0]          angle,
  output logic signed [FRAC_BITS+1:0] sin_q,
  output logic signed [FRAC_BITS+1:0] cos_q
);

  localparam int OW  = FRAC_BITS + 2;
  localparam int SH  = 32 - FRAC_BITS;
  localparam int ABW = (ANGLE_BITS < FIELD_W) ? ANGLE_BITS : FIELD_W;

  logic signed [CW-1:0] xs [CORDIC_STAGES+1];
  logic signed [CW-1:0] ys [CORDIC_STAGES+1];
  logic signed [33:0]   zs [CORDIC_STAGES+1];
  logic                 fl [CORDIC_STAGES+1];

  logic [31:0] a_scaled;
  logic [31:0] a_fold;
  logic        flip_in;

  // scale to 32-bit turn and fold quadrants 1 and 2 by half a turn
  always_comb begin
    a_scaled = 32'(angle[ABW-1:0]) << (32 - ABW);
    flip_in  = a_scaled[31] ^ a_scaled[30];
    a_fold   = flip_in ? (a_scaled + 32'h8000_0000) : a_scaled;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= 34'(signed'(a_fold));
      fl[0] <= flip_in;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [33:0] AT = 34'(atan_lut(i));
    logic signed [CW-1:0] dx, dy;
    assign dx = xs[i] >>> ((i < CW) ? i : CW - 1);
    assign dy = ys[i] >>> ((i < CW) ? i : CW - 1);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - AT;
        end else begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + AT;
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  // negate, round half up, saturate
  function automatic logic signed [OW-1:0] rnd_sat(input logic signed [CW-1:0] v,
                                                    input logic neg);
    logic signed [CW:0] w, r;
    logic signed [CW:0] one;
    w   = neg ? -(CW+1)'(v) : (CW+1)'(v);
    r   = (w + ((CW+1)'(1) <<< (SH - 1))) >>> SH;
    one = (CW+1)'(1) <<< FRAC_BITS;
    if (r > one) return OW'(one);
    if (r < -one) return OW'(-one);
    return OW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= rnd_sat(xs[CORDIC_STAGES], fl[CORDIC_STAGES]);
      sin_q <= rnd_sat(ys[CORDIC_STAGES], fl[CORDIC_STAGES]);
    end
  end

endmodule

### hw/rtl/ezr_merge.sv
// Matrix assembly: two product stages; the second also sums, rounds and saturates.
module ezr_merge import ezr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+1:0] sf, cf, st, ct, sp, cp,
  output logic [FIELD_W-1:0]          m [9]
);

  localparam int OW = FRAC_BITS + 2;
  localparam int PW = 2 * OW + 2;
  localparam int TW = 3 * OW + 2;

  function automatic logic signed [TW-1:0] rsat(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r, one;
    r   = (v + (TW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    one = TW'(1) <<< FRAC_BITS;
    if (r > one) return one;
    if (r < -one) return -one;
    return r;
  endfunction

  // stage 1: pair products (rounded where they feed a triple)
  // -cT*sF is negated before rounding since round half up is not symmetric
  logic signed [OW+1:0]  t_cc, t_ncs;
  logic signed [PW-1:0]  p_sfsp, p_cfsp, p_sfcp, p_cfcp;
  logic signed [PW-1:0]  p_stcp, p_stsp, p_stcf, p_stsf;
  logic signed [OW-1:0]  cp1, sp1, ct1;

  always_ff @(posedge clk) begin
    if (en) begin
      t_cc   <= (OW+2)'(rsat(TW'(ct) * TW'(cf)));
      t_ncs  <= (OW+2)'(rsat(-(TW'(ct) * TW'(sf))));
      p_sfsp <= PW'(sf) * PW'(sp);
      p_cfsp <= PW'(cf) * PW'(sp);
      p_sfcp <= PW'(sf) * PW'(cp);
      p_cfcp <= PW'(cf) * PW'(cp);
      p_stcp <= PW'(st) * PW'(cp);
      p_stsp <= PW'(st) * PW'(sp);
      p_stcf <= PW'(st) * PW'(cf);
      p_stsf <= PW'(st) * PW'(sf);
      cp1 <= cp; sp1 <= sp; ct1 <= ct;
    end
  end

  // stage 2: triple products, sums, rounding
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= FIELD_W'(rsat(TW'(t_cc) * TW'(cp1) - TW'(p_sfsp)));
      m[1] <= FIELD_W'(rsat(TW'(t_ncs) * TW'(cp1) - TW'(p_cfsp)));
      m[2] <= FIELD_W'(rsat(TW'(p_stcp)));
      m[3] <= FIELD_W'(rsat(TW'(t_cc) * TW'(sp1) + TW'(p_sfcp)));
      m[4] <= FIELD_W'(rsat(TW'(t_ncs) * TW'(sp1) + TW'(p_cfcp)));
      m[5] <= FIELD_W'(rsat(TW'(p_stsp)));
      m[6] <= FIELD_W'(rsat(-TW'(p_stcf)));
      m[7] <= FIELD_W'(rsat(TW'(p_stsf)));
      m[8] <= FIELD_W'(ct1);
    end
  end

endmodule
